/* rtl/core/dss_pkg.sv */
// Shared types and constants for the disk seek scheduler.
package dss_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TRACK_COUNT_DEF = 256;
	localparam logic [7:0] START_RESET = 8'd100;
	localparam logic [14:0] SEEK_MAX = 15'h7fff;

	// Cells per chain segment; a register follows every full segment but the last.
	localparam int CELL_GROUP = 4;

	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_SSTF = 2'd1;
	localparam logic [1:0] MODE_SCAN = 2'd2;
	localparam logic [1:0] MODE_CSCAN = 2'd3;

	localparam logic [1:0] PICK_NEAREST = 2'd0;
	localparam logic [1:0] PICK_RIGHT = 2'd1;
	localparam logic [1:0] PICK_LEFT = 2'd2;
	localparam logic [1:0] PICK_LOWEST = 2'd3;

	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_START = 1'b1;

	// Running best candidate passed from cell to cell.
	typedef struct packed {
		logic found;
		logic [8:0] key;
		logic [5:0] idx;
		logic [7:0] track;
	} cand_t;
endpackage

/* rtl/core/dss_cell.sv */
// One queue entry: holds a request and its served mark and folds itself into the pick.
module dss_cell
	import dss_pkg::*;
#(
	parameter int IDX_W = 4,
	parameter logic [5:0] MY_INDEX = 6'd0
) (
	input logic clk,
	input logic arst_n,
	input logic load_en,
	input logic [7:0] load_track,
	input logic clear,
	input logic mark_en,
	input logic [IDX_W-1:0] mark_idx,
	input logic occupied,
	input logic [1:0] how,
	input logic [7:0] head,
	input cand_t cand_in,
	output cand_t cand_out
);
	logic [7:0] track_q;
	logic served_q;
	logic elig;
	logic [8:0] key;

	always_ff @(posedge clk) begin
		if (load_en) track_q <= load_track;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) served_q <= 1'b0;
		else if (clear) served_q <= 1'b0;
		else if (mark_en && mark_idx == MY_INDEX[IDX_W-1:0]) served_q <= 1'b1;
	end

	always_comb begin
		elig = occupied && !served_q;
		if (how == PICK_RIGHT && track_q < head) elig = 1'b0;
		if (how == PICK_LEFT && track_q > head) elig = 1'b0;
		if (how == PICK_LOWEST) key = {1'b0, track_q};
		else if (track_q > head) key = {1'b0, track_q - head};
		else key = {1'b0, head - track_q};
		cand_out = cand_in;
		// Strict compare keeps the lowest index on ties.
		if (elig && (!cand_in.found || key < cand_in.key)) begin
			cand_out.found = 1'b1;
			cand_out.key = key;
			cand_out.idx = MY_INDEX;
			cand_out.track = track_q;
		end
	end
endmodule

/* rtl/core/dss_chain.sv */
// Row of request cells; the candidate ripples through in registered groups of four.
module dss_chain
	import dss_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int IDX_W = 4
) (
	input logic clk,
	input logic arst_n,
	input logic load_en,
	input logic [IDX_W-1:0] load_idx,
	input logic [7:0] load_track,
	input logic clear,
	input logic mark_en,
	input logic [IDX_W-1:0] mark_idx,
	input logic [6:0] count,
	input logic [1:0] how,
	input logic [7:0] head,
	input logic [IDX_W-1:0] fcfs_idx,
	output logic [7:0] fcfs_track,
	output cand_t result
);
	cand_t link [QUEUE_DEPTH+1];
	logic [7:0] tracks [QUEUE_DEPTH];

	assign link[0] = '0;
	genvar g;
	for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		cand_t cell_out;
		dss_cell #(.IDX_W(IDX_W), .MY_INDEX(6'(g))) u_cell (
			.clk, .arst_n,
			.load_en(load_en && load_idx == IDX_W'(g)),
			.load_track, .clear, .mark_en, .mark_idx,
			.occupied(count > 7'(g)), .how, .head,
			.cand_in(link[g]), .cand_out(cell_out)
		);
		// The last cell of each full group, unless it ends the chain, hands its candidate on through a register.
		if ((g % CELL_GROUP) == CELL_GROUP - 1 && g != QUEUE_DEPTH - 1) begin : g_reg
			cand_t hold_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) hold_q <= '0;
				else hold_q <= cell_out;
			end
			assign link[g+1] = hold_q;
		end else begin : g_pass
			assign link[g+1] = cell_out;
		end
		always_ff @(posedge clk) begin
			if (load_en && load_idx == IDX_W'(g)) tracks[g] <= load_track;
		end
	end
	assign fcfs_track = tracks[fcfs_idx];
	assign result = link[QUEUE_DEPTH];
endmodule

/* rtl/core/disk_seek_scheduler_core.sv */
// Top level of the disk seek scheduler.
// Usage: write policy_mode (index 0) and start_track (index 1) through
// cfg_we/cfg_index/cfg_data while idle. Pulse start with request_track and
// batch_last while busy is low; one request loads per cycle. The item with
// batch_last starts service: busy rises and every served request appears on
// served_track, served_index, seek_total and run_last for one cycle with
// result_valid high. The receiver cannot stall results.
// Under FCFS each pick reads the entry in ST_EVAL and retires it in ST_SERVE.
// The other policies let the candidate settle through the cell chain, which
// holds a register after every full group of four cells but the last, then
// retire it in ST_SERVE; SCAN and CSCAN may need a second chain pass when
// nothing lies ahead.
// Busy drops in the cycle that shows the last result.
// An empty batch returns nothing and leaves the block idle.
// Reset clears the queue count, served marks and control registers to defaults.
module disk_seek_scheduler_core
	import dss_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [7:0] request_track,
	input logic batch_last,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data,
	output logic result_valid,
	output logic [7:0] served_track,
	output logic [5:0] served_index,
	output logic [14:0] seek_total,
	output logic run_last
);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [8:0] TMAX = 9'(TRACK_COUNT - 1);
	localparam int GROUPS = (QUEUE_DEPTH + CELL_GROUP - 1) / CELL_GROUP;
	localparam logic [3:0] SETTLE = 4'(GROUPS - 1);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_EVAL = 3'b010,
		ST_SERVE = 3'b100
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [7:0] start_q;
	logic [6:0] count_q, done_q;
	logic [7:0] head_q;
	logic right_q, retry_q;
	logic [14:0] sum_q;
	logic [3:0] settle_q;
	logic [1:0] how;
	cand_t chain_res, pick_q;
	logic [7:0] fcfs_track;
	logic accept, load_en, mark_en, clear;
	logic [7:0] step;
	logic [15:0] sum_next;

	assign accept = start && !busy;
	assign busy = (state_q != ST_LOAD);
	assign load_en = accept && count_q < 7'(QUEUE_DEPTH) && {1'b0, request_track} <= TMAX;

	always_comb begin
		unique case (mode_q)
			MODE_SSTF: how = PICK_NEAREST;
			MODE_SCAN: how = (right_q ^ retry_q) ? PICK_RIGHT : PICK_LEFT;
			MODE_CSCAN: how = retry_q ? PICK_LOWEST : PICK_RIGHT;
			default: how = PICK_NEAREST;
		endcase
	end

	dss_chain #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_chain (
		.clk, .arst_n, .load_en, .load_idx(count_q[IDX_W-1:0]),
		.load_track(request_track), .clear, .mark_en,
		.mark_idx(pick_q.idx[IDX_W-1:0]), .count(count_q), .how, .head(head_q),
		.fcfs_idx(done_q[IDX_W-1:0]), .fcfs_track, .result(chain_res)
	);

	assign mark_en = (state_q == ST_SERVE);
	assign clear = (state_q == ST_SERVE) && (done_q + 7'd1 == count_q);
	assign step = (pick_q.track > head_q) ? pick_q.track - head_q : head_q - pick_q.track;
	assign sum_next = {1'b0, sum_q} + {8'd0, step};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FCFS;
			start_q <= START_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY: mode_q <= cfg_data[1:0];
				CFG_START: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			done_q <= '0;
			head_q <= START_RESET;
			right_q <= 1'b1;
			retry_q <= 1'b0;
			sum_q <= '0;
			settle_q <= '0;
			result_valid <= 1'b0;
			pick_q <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (load_en) count_q <= count_q + 7'd1;
					if (accept && batch_last) begin
						head_q <= ({1'b0, start_q} > TMAX) ? TMAX[7:0] : start_q;
						right_q <= 1'b1;
						retry_q <= 1'b0;
						sum_q <= '0;
						done_q <= '0;
						if (count_q != 0 || load_en) state_q <= ST_EVAL;
						else count_q <= '0;
					end
				end
				ST_EVAL: begin
					if (mode_q == MODE_FCFS) begin
						pick_q.found <= 1'b1;
						pick_q.idx <= 6'(done_q);
						pick_q.track <= fcfs_track;
						state_q <= ST_SERVE;
					end else if (settle_q != SETTLE) begin
						// The chain registers still hold candidates from older inputs.
						settle_q <= settle_q + 4'd1;
					end else if (chain_res.found) begin
						pick_q <= chain_res;
						state_q <= ST_SERVE;
						settle_q <= '0;
						if (mode_q == MODE_SCAN && retry_q) right_q <= !right_q;
						retry_q <= 1'b0;
					end else begin
						settle_q <= '0;
						retry_q <= 1'b1;
					end
				end
				ST_SERVE: begin
					sum_q <= (sum_next > {1'b0, SEEK_MAX}) ? SEEK_MAX : sum_next[14:0];
					head_q <= pick_q.track;
					served_track <= pick_q.track;
					served_index <= pick_q.idx;
					seek_total <= (sum_next > {1'b0, SEEK_MAX}) ? SEEK_MAX : sum_next[14:0];
					run_last <= clear;
					result_valid <= 1'b1;
					done_q <= done_q + 7'd1;
					if (clear) begin
						state_q <= ST_LOAD;
						count_q <= '0;
					end else state_q <= ST_EVAL;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !load_en) else $error("load while busy");
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> done_q < count_q) else $error("done past count");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && run_last) |-> !busy) else $error("busy after last");
endmodule

/* tb/disk_seek_scheduler_core_tb.sv */
// Self-checking testbench for the disk seek scheduler core.
module disk_seek_scheduler_core_tb;
	import dss_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [7:0] trk;
		logic [5:0] idx;
		logic [14:0] sum;
		logic lst;
	} service_t;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] head0;
		logic [7:0] trk;
		logic lst;
		logic typed;
		service_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [7:0] request_track = '0;
	logic batch_last = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_POLICY;
	logic [7:0] cfg_data = '0;
	logic result_valid;
	logic [7:0] served_track;
	logic [5:0] served_index;
	logic [14:0] seek_total;
	logic run_last;

	// Predictor state.
	logic [1:0] cur_mode;
	logic [7:0] cur_start;
	logic [7:0] queued_tracks [DEPTH];
	logic served [DEPTH];
	int queued_count;
	int head;

	service_t pending_services [$];
	int errors = 0;
	int cycles = 0;
	row_t rows [$];

	disk_seek_scheduler_core u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		service_t got, want;
		if (result_valid) begin
			got = '{served_track, served_index, seek_total, run_last};
			if (pending_services.size() == 0) begin
				$display("%0t: unexpected service %p", $time, got);
				errors++;
			end else begin
				want = pending_services.pop_front();
				if (got !== want) begin
					$display("%0t: expected %p, got %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	function automatic int find_request(logic [1:0] how);
		int best, best_key, key, t;
		best = -1;
		best_key = 0;
		for (int i = 0; i < queued_count; i++) begin
			t = int'(queued_tracks[i]);
			if (served[i]) continue;
			if (how == PICK_RIGHT && t < head) continue;
			if (how == PICK_LEFT && t > head) continue;
			key = (how == PICK_LOWEST) ? t : (t > head ? t - head : head - t);
			if (best < 0 || key < best_key) begin
				best = i;
				best_key = key;
			end
		end
		return best;
	endfunction

	// Loads one request and, on the last one, predicts the whole service order.
	task automatic predict_request(logic [7:0] trk, logic lst, logic typed, service_t res);
		int k, done, sum, t;
		logic right;
		if (queued_count < DEPTH) begin
			queued_tracks[queued_count] = trk;
			queued_count++;
		end
		if (!lst) return;
		head = int'(cur_start);
		right = 1'b1;
		sum = 0;
		for (done = 0; done < queued_count; done++) begin
			case (cur_mode)
				MODE_FCFS: k = done;
				MODE_SSTF: k = find_request(PICK_NEAREST);
				MODE_SCAN: begin
					k = find_request(right ? PICK_RIGHT : PICK_LEFT);
					if (k < 0) begin
						right = !right;
						k = find_request(right ? PICK_RIGHT : PICK_LEFT);
					end
				end
				default: begin
					k = find_request(PICK_RIGHT);
					if (k < 0) k = find_request(PICK_LOWEST);
				end
			endcase
			t = int'(queued_tracks[k]);
			sum += (t > head) ? t - head : head - t;
			if (sum > int'(SEEK_MAX)) sum = int'(SEEK_MAX);
			head = t;
			served[k] = 1'b1;
			if (typed)
				pending_services.push_back(res);
			else
				pending_services.push_back('{t[7:0], k[5:0], sum[14:0],
					done + 1 == queued_count});
		end
		queued_count = 0;
		for (int i = 0; i < DEPTH; i++) served[i] = 1'b0;
	endtask

	// Waits until the block is done with the previous batch.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_services.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POLICY) cur_mode = val[1:0];
		else cur_start = val;
	endtask

	task automatic send_request(logic [7:0] trk, logic lst, logic typed, service_t res);
		int gap;
		request_track <= trk;
		batch_last <= lst;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_request(trk, lst, typed, res);
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(logic [1:0] m, logic [7:0] s, logic [7:0] trk, logic lst,
		logic typed = 1'b0, service_t res = '0);
		rows.push_back('{m, s, trk, lst, typed, res});
	endtask

	initial begin
		int n, len;
		logic [7:0] trk;
		logic [1:0] m;
		logic [7:0] s;
		logic between;
		cur_mode = MODE_FCFS;
		cur_start = START_RESET;
		queued_count = 0;
		for (int i = 0; i < DEPTH; i++) served[i] = 1'b0;

		// Extremes with results typed in; the first row relies on reset values.
		add_row(MODE_FCFS, START_RESET, 8'd100, 1'b1, 1'b1, '{8'd100, 6'd0, 15'd0, 1'b1});
		add_row(MODE_FCFS, START_RESET, 8'd255, 1'b1, 1'b1, '{8'd255, 6'd0, 15'd155, 1'b1});
		add_row(MODE_FCFS, 8'd0, 8'd255, 1'b1, 1'b1, '{8'd255, 6'd0, 15'd255, 1'b1});
		add_row(MODE_FCFS, 8'd255, 8'd0, 1'b1, 1'b1, '{8'd0, 6'd0, 15'd255, 1'b1});
		// SSTF, SCAN and CSCAN on the same small batch.
		for (int p = 1; p < 4; p++) begin
			m = 2'(p);
			add_row(m, 8'd50, 8'd60, 1'b0);
			add_row(m, 8'd50, 8'd40, 1'b0);
			add_row(m, 8'd50, 8'd90, 1'b0);
			add_row(m, 8'd50, 8'd10, 1'b1);
		end
		// Reversal from the top edge and ties at the bottom edge.
		add_row(MODE_SCAN, 8'd255, 8'd0, 1'b0);
		add_row(MODE_SCAN, 8'd255, 8'd255, 1'b0);
		add_row(MODE_SCAN, 8'd255, 8'd128, 1'b1);
		add_row(MODE_CSCAN, 8'd0, 8'd0, 1'b0);
		add_row(MODE_CSCAN, 8'd0, 8'd0, 1'b0);
		add_row(MODE_CSCAN, 8'd0, 8'd255, 1'b1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		between = 1'b1;
		foreach (rows[i]) begin
			if (between && (rows[i].mode != cur_mode || rows[i].head0 != cur_start)) begin
				wait_idle();
				write_reg(CFG_POLICY, {6'd0, rows[i].mode});
				write_reg(CFG_START, rows[i].head0);
			end
			send_request(rows[i].trk, rows[i].lst, rows[i].typed, rows[i].res);
			between = rows[i].lst;
		end

		// Random batches; a few overflow the queue.
		n = 0;
		while (n < 128) begin
			wait_idle();
			m = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: s = 8'd0;
				1: s = 8'd255;
				default: s = 8'($urandom_range(0, 255));
			endcase
			write_reg(CFG_POLICY, {6'd0, m});
			write_reg(CFG_START, s);
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 12);
			for (int j = 0; j < len; j++) begin
				case ($urandom_range(0, 7))
					0: trk = 8'd0;
					1: trk = 8'd255;
					2: trk = s;
					default: trk = 8'($urandom_range(0, 255));
				endcase
				send_request(trk, j == len - 1, 1'b0, '0);
				n++;
			end
		end

		start <= 1'b0;
		while (pending_services.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* files.f */
rtl/core/dss_pkg.sv
rtl/core/dss_cell.sv
rtl/core/dss_chain.sv
rtl/core/disk_seek_scheduler_core.sv
tb/disk_seek_scheduler_core_tb.sv
